### rtl/slpg_pkg.sv
// Shared types, constants and lookup functions of the status LED pattern generator.
package slpg_pkg;

    // Widths of the stream payload and of internal state
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 16;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned DUTY_W    = 8;
    localparam int unsigned PHASE_W   = 13;
    localparam int unsigned PER_W     = PHASE_W + 1;
    localparam int unsigned BIDX_W    = 7;

    // Default breathing period in ms (legal range 256 to 8191)
    localparam int unsigned BREATH_PERIOD_DEF = 4000;

    // Register reset values
    localparam logic [CFG_W-1:0]  BOOT_DURATION_RST = 16'd720;
    localparam logic [DUTY_W-1:0] FULL_DUTY_RST     = 8'd255;

    // Register indexes on the write port
    localparam logic REG_BOOT_DURATION = 1'b0;
    localparam logic REG_FULL_DUTY     = 1'b1;

    // Pattern periods in ms
    localparam logic [PER_W-1:0] PER_ONE  = 14'd1;
    localparam logic [PER_W-1:0] PER_BOOT = 14'd720;
    localparam logic [PER_W-1:0] PER_OTA  = 14'd200;
    localparam logic [PER_W-1:0] PER_CAL  = 14'd2000;
    localparam logic [PER_W-1:0] PER_SOS  = 14'd4200;

    // Breathing index step per ms: 128 steps over one period
    localparam logic [PER_W-1:0] BREATH_STEP = 14'd128;
    localparam logic [BIDX_W-1:0] BREATH_MID = 7'd64;
    localparam logic [BIDX_W:0]   BREATH_TOP = 8'd128;

    // Window edges of the OTA blink
    localparam logic [PHASE_W-1:0] OTA_ON_END = 13'd100;

    // Patterns, as shown on the result
    typedef enum logic [2:0] {
        PAT_OFF    = 3'd0,
        PAT_SOLID  = 3'd1,
        PAT_BREATH = 3'd2,
        PAT_BOOT   = 3'd3,
        PAT_OTA    = 3'd4,
        PAT_CAL    = 3'd5,
        PAT_SOS    = 3'd6
    } pattern_t;

    // Status flags of one tick, USB power in the lowest bit
    typedef struct packed {
        logic ota_active;
        logic sleeping;
        logic fault;
        logic cal_needed;
        logic link_up;
        logic maintenance;
        logic usb_pwr;
    } status_flags_t;

    // Lit windows, start inclusive and end exclusive
    localparam int unsigned BOOT_WIN_N = 3;
    localparam logic [PHASE_W-1:0] BOOT_WIN [2*BOOT_WIN_N] = '{
        13'd0, 13'd100, 13'd220, 13'd320, 13'd440, 13'd540
    };
    localparam int unsigned CAL_WIN_N = 2;
    localparam logic [PHASE_W-1:0] CAL_WIN [2*CAL_WIN_N] = '{
        13'd0, 13'd140, 13'd280, 13'd420
    };
    localparam int unsigned SOS_WIN_N = 9;
    localparam logic [PHASE_W-1:0] SOS_WIN [2*SOS_WIN_N] = '{
        13'd0, 13'd120, 13'd240, 13'd360, 13'd480, 13'd600, 13'd960, 13'd1320,
        13'd1440, 13'd1800, 13'd1920, 13'd2280, 13'd2640, 13'd2760, 13'd2880,
        13'd3000, 13'd3120, 13'd3240
    };

    // Half wave of the breathing curve, 8 + 247 * sin^4(pi * k / 128)
    localparam int unsigned BREATH_LUT_N = 65;
    localparam logic [DUTY_W-1:0] BREATH_LUT [BREATH_LUT_N] = '{
        8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd9, 8'd9,
        8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd16, 8'd18, 8'd20, 8'd22, 8'd25, 8'd28,
        8'd31, 8'd35, 8'd39, 8'd43, 8'd48, 8'd52, 8'd58, 8'd63, 8'd69, 8'd75, 8'd82,
        8'd89, 8'd96, 8'd103, 8'd110, 8'd118, 8'd126, 8'd133, 8'd141, 8'd149, 8'd157,
        8'd165, 8'd172, 8'd180, 8'd187, 8'd195, 8'd202, 8'd208, 8'd215, 8'd221, 8'd226,
        8'd231, 8'd236, 8'd240, 8'd244, 8'd247, 8'd250, 8'd252, 8'd253, 8'd254, 8'd255
    };

    // Breathing duty for a full-wave index 0..127
    function automatic logic [DUTY_W-1:0] breath_duty(logic [BIDX_W-1:0] idx);
        logic [BIDX_W:0]   mirrored;
        logic [BIDX_W-1:0] k;
        mirrored = BREATH_TOP - {1'b0, idx};
        k = (idx <= BREATH_MID) ? idx : mirrored[BIDX_W-1:0];
        return (k > BREATH_MID) ? BREATH_LUT[BREATH_LUT_N-1] : BREATH_LUT[k];
    endfunction

    // Period of a pattern; off and solid hold their phase at zero
    function automatic logic [PER_W-1:0] period_of(pattern_t pat,
                                                  logic [PER_W-1:0] breath_per);
        logic [PER_W-1:0] per;
        unique case (pat)
            PAT_BREATH: per = breath_per;
            PAT_BOOT:   per = PER_BOOT;
            PAT_OTA:    per = PER_OTA;
            PAT_CAL:    per = PER_CAL;
            PAT_SOS:    per = PER_SOS;
            default:    per = PER_ONE;
        endcase
        return per;
    endfunction

endpackage

### rtl/slpg_pattern_sel.sv
// Priority selection of the LED pattern from the status flags of one tick.
module slpg_pattern_sel import slpg_pkg::*; (
    input  status_flags_t flags,
    input  logic          boot_active,
    output pattern_t      pat
);

    // Pick the highest priority pattern that applies
    always_comb begin
        if (flags.sleeping) begin
            pat = PAT_OFF;
        end else if (flags.ota_active) begin
            pat = PAT_OTA;
        end else if (boot_active) begin
            pat = PAT_BOOT;
        end else if (flags.fault) begin
            pat = PAT_SOS;
        end else if (flags.cal_needed) begin
            pat = PAT_CAL;
        end else if (flags.usb_pwr || flags.maintenance) begin
            pat = PAT_SOLID;
        end else if (flags.link_up) begin
            pat = PAT_OFF;
        end else begin
            pat = PAT_BREATH;
        end
    end

endmodule

### rtl/slpg_duty_gen.sv
// Duty value of a pattern at a given phase.
module slpg_duty_gen import slpg_pkg::*; (
    input  pattern_t            pat,
    input  logic [PHASE_W-1:0]  phase,
    input  logic [BIDX_W-1:0]   breath_idx,
    input  logic [DUTY_W-1:0]   full_duty,
    output logic [DUTY_W-1:0]   duty
);

    logic boot_lit;
    logic cal_lit;
    logic sos_lit;

    // Test the phase against every lit window in parallel
    always_comb begin
        boot_lit = 1'b0;
        for (int n = 0; n < BOOT_WIN_N; n++) begin
            if (phase >= BOOT_WIN[2*n] && phase < BOOT_WIN[2*n+1]) boot_lit = 1'b1;
        end
        cal_lit = 1'b0;
        for (int n = 0; n < CAL_WIN_N; n++) begin
            if (phase >= CAL_WIN[2*n] && phase < CAL_WIN[2*n+1]) cal_lit = 1'b1;
        end
        sos_lit = 1'b0;
        for (int n = 0; n < SOS_WIN_N; n++) begin
            if (phase >= SOS_WIN[2*n] && phase < SOS_WIN[2*n+1]) sos_lit = 1'b1;
        end
    end

    // Map pattern and window to a duty
    always_comb begin
        unique case (pat)
            PAT_SOLID:  duty = full_duty;
            PAT_BREATH: duty = breath_duty(breath_idx);
            PAT_BOOT:   duty = boot_lit ? full_duty : '0;
            PAT_OTA:    duty = (phase < OTA_ON_END) ? full_duty : '0;
            PAT_CAL:    duty = cal_lit ? full_duty : '0;
            PAT_SOS:    duty = sos_lit ? full_duty : '0;
            default:    duty = '0;
        endcase
    end

endmodule

### rtl/status_led_pattern_generator.sv
// Top level of the status LED pattern generator: registers, state update and handshakes.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tdata[6:0] status flags of one tick
//  m_       | out       | m_tvalid/m_tready  | m_tdata[7:0] duty, [10:8] pattern
//  cfg_     | in        | cfg_wr_en          | cfg_addr index, cfg_wdata value
//
// One item per cycle sustained while m_tready is high; each accepted item passes from the
// input register through the pattern logic into the result register.
// Reset (aresetn low, synchronous) empties both registers and restores the boot timer,
// the boot pattern, a zero phase and the register defaults.
// A stalled result holds in the result register while the input register still takes
// one more item; s_tready drops only when both are full and m_tready is low.
module status_led_pattern_generator import slpg_pkg::*; #(
    parameter int unsigned BREATH_PERIOD_MS = BREATH_PERIOD_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // usb_pwr, maintenance, link_up, cal_needed, fault,
    // sleeping, ota_active, one zero pad bit
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // duty[7:0], active_pattern[10:8], zero pad [15:11]
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam logic [PER_W-1:0] BREATH_PER = PER_W'(BREATH_PERIOD_MS);

    // Configuration registers
    logic [CFG_W-1:0]   boot_duration_reg;
    logic [DUTY_W-1:0]  full_duty_reg;

    // Input register
    logic               in_valid_reg, in_valid_next;
    status_flags_t      in_flags_reg;

    // Pattern state
    logic [CFG_W-1:0]   boot_elapsed_reg, boot_elapsed_next;
    pattern_t           cur_pat_reg;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [BIDX_W-1:0]  bidx_reg, bidx_next;
    logic [PHASE_W-1:0] brem_reg, brem_next;

    // Result register
    logic               out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0]  out_duty_reg;
    pattern_t           out_pat_reg;

    logic               advance;
    logic               boot_active;
    pattern_t           pat;
    logic               restart;
    logic [PER_W-1:0]   per;
    logic [PHASE_W-1:0] t;
    logic [PER_W-1:0]   t_inc;
    logic [BIDX_W-1:0]  bidx_cur;
    logic [PHASE_W-1:0] brem_cur;
    logic [PER_W-1:0]   brem_add;
    logic [PER_W-1:0]   brem_sub;
    logic [DUTY_W-1:0]  duty;

    // Handshake: move an item on when the result register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - DUTY_W - 3)'(0), out_pat_reg, out_duty_reg};

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Boot timer, tested before it counts
    assign boot_active = boot_elapsed_reg < boot_duration_reg;
    assign boot_elapsed_next = boot_active ? boot_elapsed_reg + 1'b1 : boot_elapsed_reg;

    slpg_pattern_sel u_sel (
        .flags       (in_flags_reg),
        .boot_active (boot_active),
        .pat         (pat)
    );

    // Phase of this tick: restart on a pattern change or when the held phase is past the period
    always_comb begin
        per      = period_of(pat, BREATH_PER);
        restart  = (pat != cur_pat_reg) || ({1'b0, phase_reg} >= per);
        t        = restart ? '0 : phase_reg;
        bidx_cur = restart ? '0 : bidx_reg;
        brem_cur = restart ? '0 : brem_reg;
    end

    // Advance the phase and the breathing index, which tracks phase * 128 / period
    always_comb begin
        t_inc    = {1'b0, t} + 1'b1;
        brem_add = {1'b0, brem_cur} + BREATH_STEP;
        brem_sub = brem_add - BREATH_PER;
        if (t_inc >= per) begin
            phase_next = '0;
            bidx_next  = '0;
            brem_next  = '0;
        end else if (brem_add >= BREATH_PER) begin
            phase_next = t_inc[PHASE_W-1:0];
            bidx_next  = bidx_cur + 1'b1;
            brem_next  = brem_sub[PHASE_W-1:0];
        end else begin
            phase_next = t_inc[PHASE_W-1:0];
            bidx_next  = bidx_cur;
            brem_next  = brem_add[PHASE_W-1:0];
        end
    end

    slpg_duty_gen u_duty (
        .pat        (pat),
        .phase      (t),
        .breath_idx (bidx_cur),
        .full_duty  (full_duty_reg),
        .duty       (duty)
    );

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            boot_duration_reg <= BOOT_DURATION_RST;
            full_duty_reg     <= FULL_DUTY_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_BOOT_DURATION: boot_duration_reg <= cfg_wdata;
                REG_FULL_DUTY:     full_duty_reg     <= cfg_wdata[DUTY_W-1:0];
                default:           ;
            endcase
        end
    end

    // Control and pattern state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            boot_elapsed_reg <= '0;
            cur_pat_reg      <= PAT_BOOT;
            phase_reg        <= '0;
            bidx_reg         <= '0;
            brem_reg         <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                boot_elapsed_reg <= boot_elapsed_next;
                cur_pat_reg      <= pat;
                phase_reg        <= phase_next;
                bidx_reg         <= bidx_next;
                brem_reg         <= brem_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_flags_reg <= status_flags_t'(s_tdata[$bits(status_flags_t)-1:0]);
        end
        if (advance) begin
            out_duty_reg <= duty;
            out_pat_reg  <= pat;
        end
    end

endmodule

### rtl/slpg_checker.sv
// Port-level checks of the status LED pattern generator, bound to the top level.
module slpg_checker import slpg_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A draining result side never blocks the input side
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while result side is ready");

    // The off pattern always gives a dark LED
    a_off_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[10:8] == PAT_OFF) |-> (m_tdata[7:0] == '0))
        else $error("off pattern with nonzero duty");

    // Breathing never drops below its floor
    a_breath_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[10:8] == PAT_BREATH) |-> (m_tdata[7:0] >= BREATH_LUT[0]))
        else $error("breathing duty below floor");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind status_led_pattern_generator slpg_checker u_slpg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
